[hw/rtl/dllc_pkg.sv]
// Shared types and constants for the doubly linked list with cursor.
package dllc_pkg;

    localparam int DEF_POOL_SIZE  = 64;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int CMD_WIDTH      = 4;
    localparam int WORD_WIDTH     = 32;
    localparam int STATUS_WIDTH   = 2;
    localparam int LEN_WIDTH      = 7;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_FIRST        = 4'd0,
        CMD_NEXT         = 4'd1,
        CMD_LAST         = 4'd2,
        CMD_PREV         = 4'd3,
        CMD_PUSH_FRONT   = 4'd4,
        CMD_PUSH_BACK    = 4'd5,
        CMD_PUSH_AFTER   = 4'd6,
        CMD_POP_FRONT    = 4'd7,
        CMD_POP_BACK     = 4'd8,
        CMD_POP_CURSOR   = 4'd9,
        CMD_CLEAR        = 4'd10
    } t_cmd;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LINK,
        S_GETDATA,
        S_ALLOC,
        S_WR1,
        S_WR2,
        S_UNLINK,
        S_RESP
    } t_state;

endpackage

[hw/rtl/doubly_linked_list_with_cursor.sv]
// Doubly linked list with cursor: node pool in link and payload memories.
// One word at a time: a new word is taken only once the last result is in the output register.
// The result is in the output register from the cycle in which the next word can be taken;
// a stalled output holds the block until that register frees.
// Reset empties the list at once; the memories need no clearing pass, and clear takes one step.
module doubly_linked_list_with_cursor #(
    parameter int POOL_SIZE  = dllc_pkg::DEF_POOL_SIZE,
    parameter int DATA_WIDTH = dllc_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dllc_pkg::CMD_WIDTH-1:0]    i_cmd,
    input  logic [dllc_pkg::WORD_WIDTH-1:0]   i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [dllc_pkg::WORD_WIDTH-1:0]   o_value_out,
    output logic [dllc_pkg::STATUS_WIDTH-1:0] o_status,
    output logic [dllc_pkg::LEN_WIDTH-1:0]    o_length
);
    import dllc_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam logic [LW-1:0] NONE_NODE = LW'(POOL_SIZE);

    function automatic logic f_is_node(input logic [LW-1:0] x);
        return x < NONE_NODE;
    endfunction

    // Memories: payload, next and prev links, and a stack of freed slots.
    logic [DATA_WIDTH-1:0] mem_pl [POOL_SIZE];
    logic [LW-1:0]         mem_nx [POOL_SIZE];
    logic [LW-1:0]         mem_pv [POOL_SIZE];
    logic [AW-1:0]         mem_fr [POOL_SIZE];

    logic                  pl_we, nx_we, pv_we, fr_we;
    logic [AW-1:0]         pl_waddr, nx_waddr, pv_waddr, fr_waddr;
    logic [AW-1:0]         pl_raddr, nx_raddr, pv_raddr, fr_raddr;
    logic [DATA_WIDTH-1:0] pl_wdata;
    logic [LW-1:0]         nx_wdata, pv_wdata;
    logic [AW-1:0]         fr_wdata;

    logic [DATA_WIDTH-1:0] r_pl_rdata;
    logic [LW-1:0]         r_nx_rdata, r_pv_rdata;
    logic [AW-1:0]         r_fr_rdata;

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            mem_pl[pl_waddr] <= pl_wdata;
        end
        r_pl_rdata <= mem_pl[pl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            mem_nx[nx_waddr] <= nx_wdata;
        end
        r_nx_rdata <= mem_nx[nx_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            mem_pv[pv_waddr] <= pv_wdata;
        end
        r_pv_rdata <= mem_pv[pv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            mem_fr[fr_waddr] <= fr_wdata;
        end
        r_fr_rdata <= mem_fr[fr_raddr];
    end

    // Control state.
    t_state         r_state, n_state;
    logic [LW-1:0]  r_head, n_head;
    logic [LW-1:0]  r_tail, n_tail;
    logic [LW-1:0]  r_cursor, n_cursor;
    logic [LW-1:0]  r_count, n_count;
    logic [LW-1:0]  r_sp, n_sp;
    logic [LW-1:0]  r_bump, n_bump;
    logic           r_out_valid, n_out_valid;

    // Datapath registers.
    t_cmd                  r_cmd, n_cmd;
    logic [WORD_WIDTH-1:0] r_value, n_value;
    logic [AW-1:0]         r_slot, n_slot;
    logic [LW-1:0]         r_c, n_c;
    logic [LW-1:0]         r_q, n_q;
    logic [LW-1:0]         r_t, n_t;
    logic                  r_from_stack, n_from_stack;
    logic                  r_res_found, n_res_found;
    logic [WORD_WIDTH-1:0] r_res_value, n_res_value;
    t_status               r_res_status, n_res_status;
    logic                  r_found;
    logic [WORD_WIDTH-1:0] r_value_out;
    t_status               r_status;
    logic [LEN_WIDTH-1:0]  r_length;
    logic                  out_load;

    logic [LW-1:0] sel_t;
    logic [LW-1:0] slot_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NONE_NODE;
            r_tail      <= NONE_NODE;
            r_cursor    <= NONE_NODE;
            r_count     <= '0;
            r_sp        <= '0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_bump      <= n_bump;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_value      <= n_value;
        r_slot       <= n_slot;
        r_c          <= n_c;
        r_q          <= n_q;
        r_t          <= n_t;
        r_from_stack <= n_from_stack;
        r_res_found  <= n_res_found;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_found     <= r_res_found;
            r_value_out <= r_res_value;
            r_status    <= r_res_status;
            r_length    <= LEN_WIDTH'(r_count);
        end
    end

    assign slot_ext = LW'(r_slot);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cursor     = r_cursor;
        n_count      = r_count;
        n_sp         = r_sp;
        n_bump       = r_bump;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_slot       = r_slot;
        n_c          = r_c;
        n_q          = r_q;
        n_t          = r_t;
        n_from_stack = r_from_stack;
        n_res_found  = r_res_found;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        out_load     = 1'b0;
        sel_t        = NONE_NODE;

        pl_we    = 1'b0;
        nx_we    = 1'b0;
        pv_we    = 1'b0;
        fr_we    = 1'b0;
        pl_waddr = r_slot;
        nx_waddr = r_slot;
        pv_waddr = r_slot;
        fr_waddr = r_sp[AW-1:0];
        pl_wdata = DATA_WIDTH'(r_value);
        nx_wdata = NONE_NODE;
        pv_wdata = NONE_NODE;
        fr_wdata = r_t[AW-1:0];
        pl_raddr = '0;
        nx_raddr = '0;
        pv_raddr = '0;
        fr_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_value = i_value;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_res_found  = 1'b0;
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_state      = S_RESP;
                case (r_cmd)
                    CMD_FIRST, CMD_LAST: begin
                        sel_t = (r_cmd == CMD_FIRST) ? r_head : r_tail;
                        if (f_is_node(sel_t)) begin
                            pl_raddr = sel_t[AW-1:0];
                            n_cursor = sel_t;
                            n_state  = S_GETDATA;
                        end else begin
                            n_res_status = ST_NONE;
                        end
                    end
                    CMD_NEXT, CMD_PREV: begin
                        if (f_is_node(r_cursor)) begin
                            nx_raddr = r_cursor[AW-1:0];
                            pv_raddr = r_cursor[AW-1:0];
                            n_state  = S_LINK;
                        end else begin
                            n_res_status = ST_NONE;
                        end
                    end
                    CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_AFTER: begin
                        sel_t = (r_cmd == CMD_PUSH_BACK) ? r_tail : r_cursor;
                        n_c   = sel_t;
                        if (r_cmd == CMD_PUSH_BACK) begin
                            n_cursor = r_tail;
                        end
                        if (r_cmd == CMD_PUSH_AFTER && !f_is_node(r_cursor)) begin
                            n_res_status = ST_NONE;
                        end else if (r_count >= NONE_NODE) begin
                            n_res_status = ST_FULL;
                        end else begin
                            // Take a freed slot if there is one, else the next fresh slot.
                            nx_raddr = sel_t[AW-1:0];
                            fr_raddr = AW'(r_sp - LW'(1));
                            if (r_sp != '0) begin
                                n_sp         = r_sp - LW'(1);
                                n_from_stack = 1'b1;
                            end else begin
                                n_slot       = r_bump[AW-1:0];
                                n_bump       = r_bump + LW'(1);
                                n_from_stack = 1'b0;
                            end
                            n_state = S_ALLOC;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CURSOR: begin
                        sel_t = (r_cmd == CMD_POP_FRONT) ? r_head :
                                (r_cmd == CMD_POP_BACK)  ? r_tail : r_cursor;
                        if (f_is_node(sel_t)) begin
                            pl_raddr = sel_t[AW-1:0];
                            nx_raddr = sel_t[AW-1:0];
                            pv_raddr = sel_t[AW-1:0];
                            n_t      = sel_t;
                            n_state  = S_UNLINK;
                        end else begin
                            n_res_status = ST_NONE;
                        end
                    end
                    CMD_CLEAR: begin
                        n_head   = NONE_NODE;
                        n_tail   = NONE_NODE;
                        n_cursor = NONE_NODE;
                        n_count  = '0;
                        n_sp     = '0;
                        n_bump   = '0;
                    end
                    default: begin
                        n_res_status = ST_NONE;
                    end
                endcase
            end

            S_LINK: begin
                sel_t = (r_cmd == CMD_NEXT) ? r_nx_rdata : r_pv_rdata;
                if (f_is_node(sel_t)) begin
                    pl_raddr = sel_t[AW-1:0];
                    n_cursor = sel_t;
                    n_state  = S_GETDATA;
                end else begin
                    n_res_status = ST_NONE;
                    n_state      = S_RESP;
                end
            end

            S_GETDATA: begin
                n_res_found = 1'b1;
                n_res_value = WORD_WIDTH'(r_pl_rdata);
                n_state     = S_RESP;
            end

            S_ALLOC: begin
                if (r_from_stack) begin
                    n_slot = r_fr_rdata;
                end
                n_q     = r_nx_rdata;
                n_count = r_count + LW'(1);
                n_state = S_WR1;
            end

            S_WR1: begin
                pl_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                if (r_cmd == CMD_PUSH_FRONT) begin
                    nx_wdata = r_head;
                    pv_wdata = NONE_NODE;
                    if (f_is_node(r_head)) begin
                        n_state = S_WR2;
                    end else begin
                        n_tail  = slot_ext;
                        n_head  = slot_ext;
                        n_state = S_RESP;
                    end
                end else if (!f_is_node(r_c)) begin
                    // Push at the back of an empty list makes the only node.
                    nx_wdata = NONE_NODE;
                    pv_wdata = NONE_NODE;
                    n_head   = slot_ext;
                    n_tail   = slot_ext;
                    n_state  = S_RESP;
                end else begin
                    nx_wdata = r_q;
                    pv_wdata = r_c;
                    n_state  = S_WR2;
                end
            end

            S_WR2: begin
                n_state = S_RESP;
                if (r_cmd == CMD_PUSH_FRONT) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_head[AW-1:0];
                    pv_wdata = slot_ext;
                    n_head   = slot_ext;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = r_c[AW-1:0];
                    nx_wdata = slot_ext;
                    if (f_is_node(r_q)) begin
                        pv_we    = 1'b1;
                        pv_waddr = r_q[AW-1:0];
                        pv_wdata = slot_ext;
                    end else begin
                        n_tail = slot_ext;
                    end
                end
            end

            S_UNLINK: begin
                // Prev data is the predecessor, next data the successor.
                if (f_is_node(r_pv_rdata)) begin
                    nx_we    = 1'b1;
                    nx_waddr = r_pv_rdata[AW-1:0];
                    nx_wdata = r_nx_rdata;
                end
                if (f_is_node(r_nx_rdata)) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_nx_rdata[AW-1:0];
                    pv_wdata = r_pv_rdata;
                end
                if (r_t == r_head) begin
                    n_head = r_nx_rdata;
                end
                if (r_t == r_tail) begin
                    n_tail = r_pv_rdata;
                end
                fr_we       = 1'b1;
                n_sp        = r_sp + LW'(1);
                n_count     = r_count - LW'(1);
                n_cursor    = NONE_NODE;
                n_res_found = 1'b1;
                n_res_value = WORD_WIDTH'(r_pl_rdata);
                n_state     = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_value_out = r_value_out;
    assign o_status    = r_status;
    assign o_length    = r_length;

endmodule

[tb/list_response_checker.sv]
`timescale 1ns / 1ps
// Checker for the linked list block: predicts each response and compares it field by field.
module list_response_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [dllc_pkg::CMD_WIDTH-1:0]    i_cmd,
    input  logic [dllc_pkg::WORD_WIDTH-1:0]   i_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_found,
    input  logic [dllc_pkg::WORD_WIDTH-1:0]   i_value_out,
    input  logic [dllc_pkg::STATUS_WIDTH-1:0] i_status,
    input  logic [dllc_pkg::LEN_WIDTH-1:0]    i_length,
    output int                                o_fail_count,
    output int                                o_pending
);
    import dllc_pkg::*;

    localparam logic [LEN_WIDTH-1:0] POOL_NODES = LEN_WIDTH'(DEF_POOL_SIZE);
    // A link equal to the pool size marks the absence of a node.
    localparam logic [LEN_WIDTH-1:0] NIL = POOL_NODES;

    typedef struct packed {
        logic                  found;
        logic [WORD_WIDTH-1:0] word;
        t_status               status;
        logic [LEN_WIDTH-1:0]  length;
    } t_list_response;

    logic [WORD_WIDTH-1:0]    word_mem [DEF_POOL_SIZE];
    logic [LEN_WIDTH-1:0]     fwd      [DEF_POOL_SIZE];
    logic [LEN_WIDTH-1:0]     back     [DEF_POOL_SIZE];
    logic [DEF_POOL_SIZE-1:0] used;
    logic [LEN_WIDTH-1:0]     head;
    logic [LEN_WIDTH-1:0]     tail;
    logic [LEN_WIDTH-1:0]     cur;
    logic [LEN_WIDTH-1:0]     count;

    t_list_response expected_responses[$];
    int fails = 0;

    function automatic logic is_live(input logic [LEN_WIDTH-1:0] idx);
        return idx < NIL;
    endfunction

    // New nodes always land in the lowest free slot.
    function automatic logic [LEN_WIDTH-1:0] grab_slot(input logic [WORD_WIDTH-1:0] w);
        for (int i = 0; i < DEF_POOL_SIZE; i++) begin
            if (!used[i]) begin
                used[i]     = 1'b1;
                word_mem[i] = w;
                fwd[i]      = NIL;
                back[i]     = NIL;
                count       = count + 1'b1;
                return LEN_WIDTH'(i);
            end
        end
        return NIL;
    endfunction

    function automatic void link_after(input logic [LEN_WIDTH-1:0] c,
                                       input logic [WORD_WIDTH-1:0] w);
        logic [LEN_WIDTH-1:0] n;
        logic [LEN_WIDTH-1:0] q;
        n = grab_slot(w);
        q = fwd[c];
        fwd[n] = q;
        if (is_live(q)) back[q] = n;
        back[n] = c;
        fwd[c] = n;
        if (!is_live(q)) tail = n;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] detach(input logic [LEN_WIDTH-1:0] n);
        logic [LEN_WIDTH-1:0] p;
        logic [LEN_WIDTH-1:0] q;
        p = back[n];
        q = fwd[n];
        if (is_live(p)) fwd[p] = q;
        if (is_live(q)) back[q] = p;
        if (n == head) head = q;
        if (n == tail) tail = p;
        used[n] = 1'b0;
        if (count > 0) count = count - 1'b1;
        cur = NIL;
        return word_mem[n];
    endfunction

    function automatic t_list_response predict_list_response(
        input logic [CMD_WIDTH-1:0]  code,
        input logic [WORD_WIDTH-1:0] w
    );
        t_list_response r;
        logic [LEN_WIDTH-1:0] t;
        r = '0;
        r.status = ST_OK;
        case (code)
            CMD_FIRST, CMD_NEXT, CMD_LAST, CMD_PREV: begin
                if (code == CMD_FIRST) t = head;
                else if (code == CMD_LAST) t = tail;
                else if (!is_live(cur)) t = NIL;
                else if (code == CMD_NEXT) t = fwd[cur];
                else t = back[cur];
                if (is_live(t)) begin
                    cur     = t;
                    r.found = 1'b1;
                    r.word  = word_mem[t];
                end else begin
                    r.status = ST_NONE;
                end
            end
            CMD_PUSH_FRONT: begin
                if (count >= POOL_NODES) begin
                    r.status = ST_FULL;
                end else begin
                    t = grab_slot(w);
                    fwd[t] = head;
                    if (is_live(head)) back[head] = t;
                    else tail = t;
                    head = t;
                end
            end
            CMD_PUSH_BACK: begin
                // The cursor lands on the old tail even when the push is refused.
                cur = tail;
                if (count >= POOL_NODES) begin
                    r.status = ST_FULL;
                end else if (!is_live(tail)) begin
                    t = grab_slot(w);
                    head = t;
                    tail = t;
                end else begin
                    link_after(tail, w);
                end
            end
            CMD_PUSH_AFTER: begin
                if (!is_live(cur)) r.status = ST_NONE;
                else if (count >= POOL_NODES) r.status = ST_FULL;
                else link_after(cur, w);
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CURSOR: begin
                t = (code == CMD_POP_FRONT) ? head : (code == CMD_POP_BACK) ? tail : cur;
                if (is_live(t)) begin
                    r.found = 1'b1;
                    r.word  = detach(t);
                end else begin
                    r.status = ST_NONE;
                end
            end
            CMD_CLEAR: begin
                used  = '0;
                head  = NIL;
                tail  = NIL;
                cur   = NIL;
                count = '0;
            end
            default: r.status = ST_NONE;
        endcase
        r.length = count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_response want;
        if (!i_rst_n) begin
            used  = '0;
            head  = NIL;
            tail  = NIL;
            cur   = NIL;
            count = '0;
            expected_responses.delete();
        end else begin
            // Compare before queuing, so a response is never matched to the word
            // accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    $error("response with no word outstanding: found %0d value_out %h",
                           i_found, i_value_out);
                    fails++;
                end else begin
                    want = expected_responses.pop_front();
                    if (i_found !== want.found) begin
                        $error("found mismatch: expected %0d, actual %0d", want.found, i_found);
                        fails++;
                    end
                    if (i_value_out !== want.word) begin
                        $error("value_out mismatch: expected %h, actual %h",
                               want.word, i_value_out);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        fails++;
                    end
                    if (i_length !== want.length) begin
                        $error("length mismatch: expected %0d, actual %0d",
                               want.length, i_length);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_responses.push_back(predict_list_response(i_cmd, i_value));
        end
        o_fail_count <= fails;
        o_pending    <= expected_responses.size();
    end

endmodule

[tb/doubly_linked_list_with_cursor_tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives list commands with random gaps and stalls and gives the verdict.
module doubly_linked_list_with_cursor_tb;
    import dllc_pkg::*;

    localparam int WORDS_TO_SEND     = 1100;
    localparam int IDLE_LIMIT        = 2000;
    localparam int FIRST_UNUSED_CODE = int'(CMD_CLEAR) + 1;
    localparam int LAST_CODE         = (1 << CMD_WIDTH) - 1;

    typedef enum {MIX_FILL, MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [CMD_WIDTH-1:0]    i_cmd = '0;
    logic [WORD_WIDTH-1:0]   i_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_found;
    logic [WORD_WIDTH-1:0]   o_value_out;
    logic [STATUS_WIDTH-1:0] o_status;
    logic [LEN_WIDTH-1:0]    o_length;

    int   fail_count;
    int   responses_pending;
    int   words_sent = 0;
    int   idle_cycles = 0;
    int   ready_hold = 0;
    logic quiet = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    doubly_linked_list_with_cursor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_length    (o_length)
    );

    list_response_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_found      (o_found),
        .i_value_out  (o_value_out),
        .i_status     (o_status),
        .i_length     (o_length),
        .o_fail_count (fail_count),
        .o_pending    (responses_pending)
    );

    // Receiver side: runs of ready and stalls, mostly short, now and then long.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (quiet || $urandom_range(0, 3) != 0) begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("doubly_linked_list_with_cursor_tb failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (quiet || roll < 6) return 0;
        if (roll < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [WORD_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_WIDTH-1:0] pick_command(input traffic_mix_t mix);
        int roll;
        int push_pct;
        int move_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:   begin push_pct = 90; move_pct = 8;  pop_pct = 0;  end
            MIX_GROW:   begin push_pct = 55; move_pct = 28; pop_pct = 12; end
            MIX_SHRINK: begin push_pct = 15; move_pct = 25; pop_pct = 55; end
            default:    begin push_pct = 30; move_pct = 38; pop_pct = 27; end
        endcase
        if (roll < push_pct) begin
            case ($urandom_range(0, 2))
                0:       return CMD_PUSH_FRONT;
                1:       return CMD_PUSH_BACK;
                default: return CMD_PUSH_AFTER;
            endcase
        end else if (roll < push_pct + move_pct) begin
            case ($urandom_range(0, 3))
                0:       return CMD_FIRST;
                1:       return CMD_NEXT;
                2:       return CMD_LAST;
                default: return CMD_PREV;
            endcase
        end else if (roll < push_pct + move_pct + pop_pct) begin
            case ($urandom_range(0, 2))
                0:       return CMD_POP_FRONT;
                1:       return CMD_POP_BACK;
                default: return CMD_POP_CURSOR;
            endcase
        end else if (mix != MIX_FILL && $urandom_range(0, 2) == 0) begin
            return CMD_CLEAR;
        end
        return CMD_WIDTH'($urandom_range(FIRST_UNUSED_CODE, LAST_CODE));
    endfunction

    // Valid stays up until the word is taken; it drops only if a gap follows.
    task automatic send_word(input logic [CMD_WIDTH-1:0] code, input logic [WORD_WIDTH-1:0] w);
        int gap;
        i_in_valid <= 1'b1;
        i_cmd      <= code;
        i_value    <= w;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        words_sent++;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (responses_pending != 0);
    endtask

    initial begin
        traffic_mix_t mix;
        int seg;
        int seg_len;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Moves and pops on an empty list first, then a short list built and stepped from each end.
        send_word(CMD_FIRST, '0);
        send_word(CMD_NEXT, '0);
        send_word(CMD_LAST, '0);
        send_word(CMD_PREV, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_CURSOR, '0);
        send_word(CMD_PUSH_AFTER, 32'h1111_1111);
        send_word(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(CMD_PUSH_FRONT, 32'h0000_0000);
        send_word(CMD_PUSH_FRONT, 32'hA5A5_A5A5);
        send_word(CMD_PUSH_BACK, 32'h5A5A_5A5A);
        send_word(CMD_PUSH_AFTER, 32'h0123_4567);
        send_word(CMD_FIRST, '0);
        send_word(CMD_NEXT, '0);
        send_word(CMD_PREV, '0);
        send_word(CMD_LAST, '0);
        send_word(CMD_NEXT, '0);
        send_word(CMD_POP_CURSOR, '0);
        send_word(CMD_NEXT, '0);
        send_word(CMD_WIDTH'(FIRST_UNUSED_CODE), 32'hDEAD_BEEF);
        send_word(CMD_WIDTH'(LAST_CODE), 32'hFFFF_FFFF);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_CLEAR, '0);

        // The first segment fills the pool past capacity; later ones are drawn at random.
        seg = 0;
        while (words_sent < WORDS_TO_SEND) begin
            mix = (seg == 0) ? MIX_FILL : traffic_mix_t'($urandom_range(0, 3));
            seg_len = (mix == MIX_FILL) ? 90 : $urandom_range(20, 80);
            quiet <= ($urandom_range(0, 4) == 0);
            repeat (seg_len) send_word(pick_command(mix), pick_value());
            if (seg == 0 || $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            seg++;
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("doubly_linked_list_with_cursor_tb passed");
        else
            $display("doubly_linked_list_with_cursor_tb failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dllc_pkg.sv
hw/rtl/doubly_linked_list_with_cursor.sv
tb/list_response_checker.sv
tb/doubly_linked_list_with_cursor_tb.sv
